>>> hdl/i2c_master_bit_engine_macros.svh
// assertion helpers shared by the engine modules
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define I2CM_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked assertion that also holds through reset
`define I2CM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

	// command codes carried in the action field
	typedef enum logic [2:0] {
		OP_IDLE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	// phase markers inside the write and read sequences
	localparam logic [4:0] WR_BITS_END  = 5'd24;
	localparam logic [4:0] WR_SCL_LOW   = 5'd24;
	localparam logic [4:0] WR_RELEASE   = 5'd25;
	localparam logic [4:0] WR_ACK_CLK   = 5'd26;
	localparam logic [4:0] RD_BITS_END  = 5'd16;
	localparam logic [4:0] RD_ACK_DRIVE = 5'd16;
	localparam logic [4:0] RD_ACK_HIGH  = 5'd17;
	localparam logic [4:0] RD_ACK_LOW   = 5'd18;
	localparam logic [4:0] RD_NACK_HIGH = 5'd16;

	// sub-phase within one written bit
	localparam logic [1:0] SUB_SCL_LOW  = 2'd0;
	localparam logic [1:0] SUB_DATA     = 2'd1;
	localparam logic [1:0] SUB_SCL_HIGH = 2'd2;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] tx_byte;
		logic       ack_req;
		logic       sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic       ack_seen;
		logic [7:0] rx_byte;
	} res_t;

	// core to output buffer
	typedef struct packed {
		logic push;
		res_t item;
	} res_push_t;

endpackage

`default_nettype wire

>>> hdl/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | handshake            | payload
// cmd     | in  | cmd_valid, cmd_stall | cmd (i2cm_pkg::cmd_t), one bus delay tick
// res     | out | res_valid, res_stall | res (i2cm_pkg::res_t), line levels and status
//
// one request per cycle unless stalled; its result is registered in the output buffer
// each request runs exactly one bus phase through the core's phase logic
// cmd_stall rises only when the output register and its skid entry both hold results
// arst_n clears the engine to idle with both lines low and the buffer empty

module i2c_master_bit_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire i2cm_pkg::cmd_t cmd,
	output logic                res_valid,
	input  wire logic           res_stall,
	output i2cm_pkg::res_t      res
);
	import i2cm_pkg::*;

	logic      accept;
	res_push_t push;
	logic      full;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = full;

	// phase logic and engine state
	i2cm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (cmd),
		.push   (push)
	);

	// result register toward the bus side consumer
	i2cm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire

>>> hdl/i2cm_core.sv
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_bit_engine_macros.svh"

module i2cm_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire i2cm_pkg::cmd_t    cmd,
	output i2cm_pkg::res_push_t    push
);
	import i2cm_pkg::*;

	op_t        op_q;
	logic [4:0] phase_q;
	logic [1:0] sub_q;
	logic [7:0] shift_q;
	logic [7:0] rx_q;
	logic       ack_q;
	logic       ackw_q;
	logic       scl_q;
	logic       sda_q;

	logic       start_cmd;
	op_t        op;
	logic [4:0] p;
	logic [1:0] sub;
	logic [7:0] shift;
	logic       ackw;

	op_t        op_n;
	logic [4:0] phase_n;
	logic [1:0] sub_n;
	logic [7:0] shift_n;
	logic [7:0] rx_n;
	logic       ack_n;
	logic       scl_n;
	logic       sda_n;
	logic       fin;
	logic       busy;

	// command pickup while idle
	always_comb begin
		start_cmd = (op_q == OP_IDLE) &&
			(cmd.action == OP_START || cmd.action == OP_STOP ||
			 cmd.action == OP_WRITE || cmd.action == OP_READ);
		op    = start_cmd ? op_t'(cmd.action) : op_q;
		p     = start_cmd ? 5'd0 : phase_q;
		sub   = start_cmd ? SUB_SCL_LOW : sub_q;
		ackw  = (start_cmd && cmd.action == OP_READ) ? cmd.ack_req : ackw_q;
		shift = shift_q;
		if (start_cmd && cmd.action == OP_WRITE) begin
			shift = cmd.tx_byte;
		end else if (start_cmd && cmd.action == OP_READ) begin
			shift = 8'd0;
		end
	end

	// one phase of the running command
	always_comb begin
		shift_n = shift;
		sub_n   = sub;
		rx_n    = rx_q;
		ack_n   = ack_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		fin     = 1'b0;
		unique case (op)
			OP_START: begin
				unique case (p)
					5'd0:    scl_n = 1'b1;
					5'd1:    sda_n = 1'b1;
					5'd2:    sda_n = 1'b0;
					default: begin
						scl_n = 1'b0;
						fin   = 1'b1;
					end
				endcase
			end
			OP_STOP: begin
				unique case (p)
					5'd0:    scl_n = 1'b1;
					5'd1:    sda_n = 1'b0;
					5'd2:    sda_n = 1'b1;
					default: begin
						scl_n = 1'b0;
						fin   = 1'b1;
					end
				endcase
			end
			OP_WRITE: begin
				if (p < WR_BITS_END) begin
					unique case (sub)
						SUB_SCL_LOW: scl_n = 1'b0;
						SUB_DATA: begin
							sda_n   = shift[7];
							shift_n = {shift[6:0], 1'b0};
						end
						default: scl_n = 1'b1;
					endcase
					sub_n = (sub == SUB_SCL_HIGH) ? SUB_SCL_LOW : sub + 2'd1;
				end else if (p == WR_SCL_LOW) begin
					scl_n = 1'b0;
				end else if (p == WR_RELEASE) begin
					sda_n = 1'b1;
				end else if (p == WR_ACK_CLK) begin
					scl_n = 1'b1;
					ack_n = !cmd.sda_in;
				end else begin
					scl_n = 1'b0;
					fin   = 1'b1;
				end
			end
			OP_READ: begin
				if (p < RD_BITS_END) begin
					if (!p[0]) begin
						scl_n   = 1'b1;
						shift_n = {shift[6:0], cmd.sda_in};
					end else begin
						scl_n = 1'b0;
					end
				end else if (ackw) begin
					if (p == RD_ACK_DRIVE) begin
						sda_n = 1'b0;
					end else if (p == RD_ACK_HIGH) begin
						scl_n = 1'b1;
					end else if (p == RD_ACK_LOW) begin
						scl_n = 1'b0;
					end else begin
						sda_n = 1'b1;
						rx_n  = shift;
						fin   = 1'b1;
					end
				end else begin
					if (p == RD_NACK_HIGH) begin
						scl_n = 1'b1;
					end else begin
						scl_n = 1'b0;
						rx_n  = shift;
						fin   = 1'b1;
					end
				end
			end
			default: ;
		endcase

		busy    = (op != OP_IDLE);
		op_n    = op;
		phase_n = p;
		if (busy) begin
			if (fin) begin
				op_n    = OP_IDLE;
				phase_n = 5'd0;
			end else begin
				phase_n = p + 5'd1;
			end
		end
	end

	// engine state, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_IDLE;
			phase_q <= 5'd0;
			sub_q   <= SUB_SCL_LOW;
			shift_q <= 8'd0;
			rx_q    <= 8'd0;
			ack_q   <= 1'b0;
			ackw_q  <= 1'b0;
			scl_q   <= 1'b0;
			sda_q   <= 1'b0;
		end else if (accept) begin
			op_q    <= op_n;
			phase_q <= phase_n;
			sub_q   <= sub_n;
			shift_q <= shift_n;
			rx_q    <= rx_n;
			ack_q   <= ack_n;
			ackw_q  <= ackw;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
		end
	end

	// result of this tick
	always_comb begin
		push.push          = accept;
		push.item.scl      = scl_n;
		push.item.sda_out  = sda_n;
		push.item.busy_res = busy;
		push.item.done_res = busy && fin;
		push.item.ack_seen = ack_n;
		push.item.rx_byte  = rx_n;
	end

	`I2CM_ASSERT_ALWAYS(a_idle_phase_zero, (op_q == OP_IDLE) |-> (phase_q == 5'd0), "idle phase")
	`I2CM_ASSERT_ALWAYS(a_sub_range, (sub_q != 2'd3), "write sub-phase out of range")
	`I2CM_ASSERT_RST(a_write_phase_range, (op_q == OP_WRITE) |-> (phase_q <= 5'd27), "write overrun")
	`I2CM_ASSERT_RST(a_short_phase_range, (op_q == OP_START || op_q == OP_STOP) |-> (phase_q <= 5'd3), "overrun")

endmodule

`default_nettype wire

>>> hdl/i2cm_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_bit_engine_macros.svh"

module i2cm_out_buf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire i2cm_pkg::res_push_t push,
	output logic                     full,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output i2cm_pkg::res_t           res
);
	import i2cm_pkg::*;

	res_t main_q;
	logic main_valid_q;
	res_t skid_q;
	logic skid_valid_q;
	logic pop;

	assign pop       = main_valid_q && !res_stall;
	assign full      = skid_valid_q;
	assign res_valid = main_valid_q;
	assign res       = main_q;

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || pop) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push.push;
			end
		end else if (push.push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : push.item;
		end else if (push.push) begin
			skid_q <= push.item;
		end
	end

	`I2CM_ASSERT_ALWAYS(a_skid_behind_main, skid_valid_q |-> main_valid_q, "skid entry without output entry")
	`I2CM_ASSERT_RST(a_no_push_when_full, skid_valid_q |-> !push.push, "request pushed into full buffer")

endmodule

`default_nettype wire
